// File: hw/rtl/qee_pkg.sv
package qee_pkg;
   localparam int FRAC_BITS_DEF = 8;
   localparam logic [15:0] SLACK_RESET = 16'd2000;
   localparam int REG_SLACK = 0;
endpackage

// File: hw/rtl/qee_if.sv
interface qee_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] period_q8;
   logic        direction;
   modport source (output valid, period_q8, direction, input ready);
   modport sink (input valid, period_q8, direction, output ready);
endinterface

interface qee_rsp_if;
   logic        valid;
   logic        ready;
   logic        line_a;
   logic        line_b;
   logic        edge_fired;
   logic signed [31:0] position;
   logic [31:0] edge_count;
   logic [31:0] late_count;
   logic [31:0] catchup_count;
   logic [31:0] resteer_count;
   logic [31:0] last_edge_time;
   modport source (output valid, line_a, line_b, edge_fired, position, edge_count,
                   late_count, catchup_count, resteer_count, last_edge_time,
                   input ready);
   modport sink (input valid, line_a, line_b, edge_fired, position, edge_count,
                 late_count, catchup_count, resteer_count, last_edge_time,
                 output ready);
endinterface

// File: hw/rtl/quadrature_edge_emitter.sv
// A beat is accepted in idle, evaluated, and its result offered in the result
//   state (idle, evaluate, result).
// A re-steer with wait still owed runs the bit-serial divide (start, quotient
//   bits, done) and a second evaluate.
// A new beat is taken only once the result has been accepted; a stalled result
//   holds the input off. Reset: synchronous, active high; all state zero but
//   the request and product registers, going_forward one, resteer_slack 2000.
module quadrature_edge_emitter #(
   parameter int FRAC_BITS = qee_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   qee_req_if.sink     req,
   qee_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int WW = 32 - FRAC_BITS;     // whole part width
   localparam int NW = 32 + WW;            // owed*want product width
   localparam logic [FRAC_BITS-1:0] FMASK = '1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_EVAL = 4'b0010, ST_DIV = 4'b0100, ST_OUT = 4'b1000
   } state_type;

   state_type st_ff, st_in;
   logic [15:0] slack_ff;
   logic [31:0] p_ff, tick_ff, prev_ff, sum_ff, istart_ff, next_ff, held_ff;
   logic        d_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [WW-1:0] iwhole_ff, owed_ff, want_ff;
   logic        wait_ff, fwd_ff, rst_ff, fine_ff, fired_ff;
   logic [1:0]  ph_ff, pins_ff;
   logic [31:0] pos_ff, edges_ff, late_ff, catch_ff, resteer_ff, last_ff;

   // Divider: product (owed - spent) * want over old whole.
   logic          div_start, div_done;
   logic [NW-1:0] div_num, div_quot;
   logic [31:0]   mul_a;

   qee_div #(.NW(NW), .DW(WW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(iwhole_ff), .done(div_done), .quot(div_quot)
   );

   function automatic logic is_early(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] df;
      df = a - b;
      return df[31];
   endfunction

   // Evaluate one tick; resteer path defers to the divider.
   logic [31:0] e_prev, e_sum, e_istart, e_next, e_held, e_pos, e_edges, e_late;
   logic [31:0] e_catch, e_resteer, e_last, spent, e_sum2;
   logic [FRAC_BITS-1:0] e_frac;
   logic [WW-1:0] e_iwhole, e_owed, e_want;
   logic e_wait, e_fwd, e_rst, e_fine, e_fired, e_div;
   logic [1:0] e_ph, e_pins;
   logic       e_stop, e_entering, fdir;

   always_comb begin
      e_prev = prev_ff; e_sum = sum_ff; e_istart = istart_ff; e_next = next_ff;
      e_held = held_ff; e_pos = pos_ff; e_edges = edges_ff; e_late = late_ff;
      e_catch = catch_ff; e_resteer = resteer_ff; e_last = last_ff;
      e_frac = frac_ff; e_iwhole = iwhole_ff; e_owed = owed_ff; e_want = want_ff;
      e_wait = wait_ff; e_fwd = fwd_ff; e_rst = rst_ff; e_fine = fine_ff;
      e_fired = 1'b0; e_ph = ph_ff; e_pins = pins_ff; e_div = 1'b0;
      e_stop = 1'b0; e_entering = 1'b0; fdir = d_ff;
      spent = tick_ff - istart_ff; e_sum2 = '0; mul_a = '0;
      if (!e_wait) begin
         if (p_ff == '0) begin
            e_prev = tick_ff; e_frac = '0; e_stop = 1'b1;
         end else begin
            if (fdir != e_fwd) begin
               e_ph = e_ph + (fdir ? 2'd3 : 2'd1); e_fwd = fdir;
            end
            e_held = p_ff;
            e_sum = {{(32-FRAC_BITS){1'b0}}, frac_ff} + p_ff;
            e_istart = prev_ff;
            e_iwhole = e_sum[31:FRAC_BITS];
            e_owed = e_iwhole;
            e_next = e_istart + {{FRAC_BITS{1'b0}}, e_owed};
            e_rst = 1'b0; e_fine = 1'b0; e_wait = 1'b1;
         end
      end
      if (!e_stop && !e_fine) begin
         if (is_early(tick_ff, e_next - {16'd0, slack_ff})) begin
            if (fdir != e_fwd) begin
               e_ph = e_ph + (fdir ? 2'd3 : 2'd1); e_fwd = fdir;
            end
            if (p_ff != e_held) begin
               e_resteer = e_resteer + 1'b1; e_rst = 1'b1; e_held = p_ff;
               spent = tick_ff - e_istart;
               if (p_ff == '0) begin
                  e_prev = tick_ff; e_frac = '0; e_wait = 1'b0; e_stop = 1'b1;
               end else begin
                  e_sum2 = {{(32-FRAC_BITS){1'b0}}, e_frac} + p_ff;
                  e_sum = e_sum2;
                  e_want = e_sum2[31:FRAC_BITS];
                  if (spent >= {{FRAC_BITS{1'b0}}, e_owed} || e_iwhole == '0) begin
                     e_owed = '0;
                     e_istart = tick_ff; e_iwhole = e_want;
                     e_next = tick_ff;
                  end else begin
                     mul_a = {{FRAC_BITS{1'b0}}, e_owed} - spent;
                     e_div = 1'b1; e_stop = 1'b1;
                  end
               end
            end
            if (!e_stop && is_early(tick_ff, e_next - {16'd0, slack_ff}))
               e_stop = 1'b1;
         end
         if (!e_stop) begin
            e_fine = 1'b1; e_entering = 1'b1;
         end
      end
      if (!e_stop && e_fine && !is_early(tick_ff, e_next)) begin
         if (e_entering) begin
            if (e_rst) e_catch = e_catch + 1'b1;
            else e_late = e_late + 1'b1;
         end
         unique case (e_ph)
            2'd0: e_pins[0] = 1'b1;
            2'd1: e_pins[1] = 1'b1;
            2'd2: e_pins[0] = 1'b0;
            default: e_pins[1] = 1'b0;
         endcase
         e_prev = e_next; e_frac = e_sum[FRAC_BITS-1:0] & FMASK; e_last = e_next;
         e_pos = e_pos + (e_fwd ? 32'd1 : 32'hFFFF_FFFF);
         e_edges = e_edges + 1'b1;
         e_ph = e_ph + (e_fwd ? 2'd1 : 2'd3);
         e_wait = 1'b0; e_fired = 1'b1;
      end
   end

   // Multiply registered into divider numerator (one 32x24 product).
   logic [NW-1:0] prod_ff;
   logic          prod_go_ff;

   always_comb begin
      st_in = st_ff; div_start = prod_go_ff; div_num = prod_ff;
      unique case (st_ff)
         ST_IDLE: if (req.valid) st_in = ST_EVAL;
         ST_EVAL: st_in = e_div ? ST_DIV : ST_OUT;
         // Wait restarts at this tick, then the phase test repeats.
         ST_DIV:  if (div_done) st_in = ST_EVAL;
         ST_OUT:  if (rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && req.valid) begin
         p_ff <= req.period_q8; d_ff <= req.direction;
      end
      prod_ff <= {{WW{1'b0}}, mul_a} * {32'd0, e_want};
      if (reset) begin
         st_ff <= ST_IDLE; slack_ff <= qee_pkg::SLACK_RESET; tick_ff <= '0;
         prev_ff <= '0; frac_ff <= '0; sum_ff <= '0; istart_ff <= '0;
         iwhole_ff <= '0; owed_ff <= '0; next_ff <= '0; held_ff <= '0;
         want_ff <= '0; wait_ff <= 1'b0; ph_ff <= '0; fwd_ff <= 1'b1;
         rst_ff <= 1'b0; fine_ff <= 1'b0; pins_ff <= '0; pos_ff <= '0;
         edges_ff <= '0; late_ff <= '0; catch_ff <= '0; resteer_ff <= '0;
         last_ff <= '0; fired_ff <= 1'b0; prod_go_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         prod_go_ff <= (st_ff == ST_EVAL) && e_div;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'(qee_pkg::REG_SLACK))
            slack_ff <= csr_pwdata[15:0];
         if (st_ff == ST_EVAL) begin
            prev_ff <= e_prev; frac_ff <= e_frac; sum_ff <= e_sum;
            istart_ff <= e_istart; iwhole_ff <= e_iwhole; owed_ff <= e_owed;
            next_ff <= e_next; held_ff <= e_held; want_ff <= e_want;
            wait_ff <= e_wait; ph_ff <= e_ph; fwd_ff <= e_fwd; rst_ff <= e_rst;
            fine_ff <= e_fine; pins_ff <= e_pins; pos_ff <= e_pos;
            edges_ff <= e_edges; late_ff <= e_late; catch_ff <= e_catch;
            resteer_ff <= e_resteer; last_ff <= e_last; fired_ff <= e_fired;
            if (!e_div) tick_ff <= tick_ff + 1'b1;
         end
         if (st_ff == ST_DIV && div_done) begin
            owed_ff <= div_quot[WW-1:0];
            istart_ff <= tick_ff; iwhole_ff <= want_ff;
            next_ff <= tick_ff + {{FRAC_BITS{1'b0}}, div_quot[WW-1:0]};
         end
      end
   end

   assign req.ready = (st_ff == ST_IDLE);
   assign rsp.valid = (st_ff == ST_OUT);
   assign rsp.line_a = pins_ff[0];
   assign rsp.line_b = pins_ff[1];
   assign rsp.edge_fired = fired_ff;
   assign rsp.position = pos_ff;
   assign rsp.edge_count = edges_ff;
   assign rsp.late_count = late_ff;
   assign rsp.catchup_count = catch_ff;
   assign rsp.resteer_count = resteer_ff;
   assign rsp.last_edge_time = last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'(qee_pkg::REG_SLACK)) ? {16'd0, slack_ff} : '0;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   a_noacc: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("accept while result pending");
   a_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> st_ff == ST_DIV) else $error("divide done out of place");
endmodule

// File: hw/rtl/qee_div.sv
// Bit-serial restoring divide: quotient = num / den, one quotient bit per cycle.
module qee_div #(
   parameter int NW = 56,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// File: tb/quadrature_edge_emitter_test.sv
`timescale 1ns / 100ps

module quadrature_edge_emitter_test;

   localparam int FRAC = qee_pkg::FRAC_BITS_DEF;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [31:0] period_q8;
      logic        direction;
   } tick_type;

   typedef struct packed {
      logic        line_a;
      logic        line_b;
      logic        edge_fired;
      logic [31:0] position;
      logic [31:0] edge_count;
      logic [31:0] late_count;
      logic [31:0] catchup_count;
      logic [31:0] resteer_count;
      logic [31:0] last_edge_time;
   } emit_type;

   logic clock = 0;
   logic reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [1:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   qee_req_if req ();
   qee_rsp_if rsp ();

   quadrature_edge_emitter dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // Predictor state, mirrors the emitter.
   logic [15:0] slack_q;
   logic [31:0] now_tick, prev_dl, sum_q, iv_start, next_dl, held_p;
   logic [7:0]  carry_q;
   logic [23:0] iv_whole, iv_owed;
   logic [1:0]  gray_idx, pins;
   logic        busy_wait, fwd, steered, fine;
   logic [31:0] pos_q, edges_q, late_q, catch_q, steer_q, last_dl;

   tick_type tick_queue[$];
   emit_type emit_queue[$];
   emit_type mon_got, mon_exp;
   int    errors = 0;
   int    mismatches = 0;
   int    cycles = 0;
   bit    hold_sender = 0;

   function automatic bit earlier(logic [31:0] a, logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   function automatic void model_reset();
      slack_q = qee_pkg::SLACK_RESET;
      now_tick = 0; prev_dl = 0; sum_q = 0; iv_start = 0; next_dl = 0; held_p = 0;
      carry_q = 0; iv_whole = 0; iv_owed = 0; gray_idx = 0; pins = 0;
      busy_wait = 0; fwd = 1; steered = 0; fine = 0;
      pos_q = 0; edges_q = 0; late_q = 0; catch_q = 0; steer_q = 0; last_dl = 0;
   endfunction

   function automatic void turn(logic d);
      if (d != fwd) begin
         gray_idx = gray_idx + (d ? 2'd3 : 2'd1);
         fwd = d;
      end
   endfunction

   function automatic void park_at(logic [31:0] t);
      prev_dl = t;
      carry_q = 0;
      busy_wait = 0;
   endfunction

   // One tick of the emitter; returns the levels and counters after it.
   function automatic emit_type step_emitter(tick_type it);
      emit_type    r;
      logic [31:0] t, spent;
      logic [23:0] want;
      logic [63:0] prod;
      bit          fired, parked, entering, coarse_hold;
      t = now_tick;
      fired = 0; parked = 0; entering = 0; coarse_hold = 0;
      if (!busy_wait) begin
         if (it.period_q8 == 0) begin
            park_at(t);
            parked = 1;
         end else begin
            turn(it.direction);
            held_p = it.period_q8;
            sum_q = {24'd0, carry_q} + it.period_q8;
            iv_start = prev_dl;
            iv_whole = sum_q[31:FRAC];
            iv_owed = iv_whole;
            next_dl = iv_start + iv_owed;
            steered = 0;
            fine = 0;
            busy_wait = 1;
         end
      end
      if (!parked) begin
         if (!fine) begin
            if (earlier(t, next_dl - slack_q)) begin
               turn(it.direction);
               if (it.period_q8 != held_p) begin
                  spent = t - iv_start;
                  steer_q++;
                  steered = 1;
                  held_p = it.period_q8;
                  if (it.period_q8 == 0) begin
                     park_at(t);
                     parked = 1;
                  end else begin
                     sum_q = {24'd0, carry_q} + it.period_q8;
                     want = sum_q[31:FRAC];
                     // Remaining wait scales with the new period.
                     if (spent >= iv_owed || iv_whole == 0) iv_owed = 0;
                     else begin
                        prod = 64'(iv_owed - spent[23:0]) * want;
                        iv_owed = 24'(prod / iv_whole);
                     end
                     iv_start = t;
                     iv_whole = want;
                     next_dl = iv_start + iv_owed;
                  end
               end
               if (!parked && earlier(t, next_dl - slack_q)) coarse_hold = 1;
            end
            if (!parked && !coarse_hold) begin
               fine = 1;
               entering = 1;
            end
         end
         if (!parked && !coarse_hold && !earlier(t, next_dl)) begin
            if (entering) begin
               if (steered) catch_q++;
               else late_q++;
            end
            case (gray_idx)
               2'd0: pins[0] = 1;
               2'd1: pins[1] = 1;
               2'd2: pins[0] = 0;
               default: pins[1] = 0;
            endcase
            prev_dl = next_dl;
            carry_q = sum_q[7:0];
            last_dl = next_dl;
            pos_q = pos_q + (fwd ? 32'd1 : 32'hFFFF_FFFF);
            edges_q++;
            gray_idx = gray_idx + (fwd ? 2'd1 : 2'd3);
            busy_wait = 0;
            fired = 1;
         end
      end
      r.line_a = pins[0];
      r.line_b = pins[1];
      r.edge_fired = fired;
      r.position = pos_q;
      r.edge_count = edges_q;
      r.late_count = late_q;
      r.catchup_count = catch_q;
      r.resteer_count = steer_q;
      r.last_edge_time = last_dl;
      now_tick = t + 1;
      return r;
   endfunction

   // Sender: bursts of random length, random gaps.
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req.valid <= 0;
         req.period_q8 <= '0;
         req.direction <= 0;
      end else begin
         if (req.valid && req.ready) begin
            emit_queue.push_back(step_emitter(tick_queue.pop_front()));
         end
         if (!(req.valid && !req.ready)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req.valid <= 0;
            end else if (tick_queue.size() != 0 && !hold_sender) begin
               req.valid <= 1;
               req.period_q8 <= tick_queue[0].period_q8;
               req.direction <= tick_queue[0].direction;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 30);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req.valid <= 0;
            end
         end
      end
   end

   // Receiver: stalls in its own pattern, with quiet stretches.
   int stall_mode = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp.ready <= 1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // Monitor: field-by-field compare against the oldest expected tick result.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         mon_got = '{rsp.line_a, rsp.line_b, rsp.edge_fired, rsp.position, rsp.edge_count,
                     rsp.late_count, rsp.catchup_count, rsp.resteer_count,
                     rsp.last_edge_time};
         if (emit_queue.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected beat: %p", mon_got);
         end else begin
            mon_exp = emit_queue.pop_front();
            if (mon_got !== mon_exp) begin
               errors++;
               if (mismatches++ < 10)
                  $display("mismatch: expected %p got %p", mon_exp, mon_got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [15:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= 2'(qee_pkg::REG_SLACK * 4); csr_pwdata <= {16'd0, v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      slack_q = v;
   endtask

   task automatic drain();
      while (tick_queue.size() != 0 || emit_queue.size() != 0 || req.valid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic void add_tick(logic [31:0] p, logic d);
      tick_type it;
      it.period_q8 = p;
      it.direction = d;
      tick_queue.push_back(it);
   endfunction

   // Random period: mostly short whole parts, some changes and parks.
   function automatic logic [31:0] pick_period();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom();
         2: return $urandom_range(1, 600);
         3: return 32'h0010_0000 | $urandom_range(0, 32'hF_FFFF);
         default: return $urandom_range(256, 256 * 40);
      endcase
   endfunction

   initial begin
      logic [31:0] p;
      logic        d;
      int          run;
      int          k;
      int          j;
      model_reset();
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed: park, short periods, reversal, extremes, re-steer and catch-up.
      csr_write(16'd4);
      add_tick(0, 0);
      add_tick(32'h0000_0100, 1);
      add_tick(32'h0000_0180, 1);
      add_tick(32'h0000_0180, 0);
      add_tick(32'h0000_0080, 0);
      add_tick(32'h0000_0001, 1);
      add_tick(32'h0000_0A00, 1);
      add_tick(32'h0000_0A00, 0);
      add_tick(32'h0000_1400, 0);
      add_tick(32'h0000_0000, 1);
      add_tick(32'h0000_2000, 1);
      add_tick(32'h0000_0100, 1);
      add_tick(32'h0000_0100, 1);
      add_tick(32'hFFFF_FFFF, 1);
      add_tick(32'h8000_0000, 0);
      add_tick(32'h0000_0000, 0);
      add_tick(32'h0000_0300, 1);
      drain();
      csr_write(16'd0);
      repeat (4) add_tick(32'h0000_0380, 1);
      add_tick(32'hFFFF_FFFF, 0);
      add_tick(0, 0);
      drain();

      // Random phases across several slack settings.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: csr_write(16'd2);
            1: csr_write(16'hFFFF);
            2: csr_write(16'd0);
            3: csr_write(16'($urandom_range(0, 64)));
            default: csr_write(qee_pkg::SLACK_RESET);
         endcase
         k = 0;
         while (k < 110) begin
            p = pick_period();
            d = ($urandom_range(0, 4) != 0);
            run = $urandom_range(1, 12);
            j = 0;
            while (j < run && k < 110) begin
               if ($urandom_range(0, 15) == 0) d = ~d;
               if ($urandom_range(0, 20) == 0) p = pick_period();
               add_tick(p, d);
               j++;
               k++;
            end
         end
         if (ph == 2) begin
            // Hold the sender until the pipeline is empty.
            while (tick_queue.size() > 50) @(posedge clock);
            hold_sender = 1;
            while (req.valid || emit_queue.size() != 0) @(posedge clock);
            repeat (5) @(posedge clock);
            hold_sender = 0;
         end
         drain();
      end
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// File: quadrature_edge_emitter.f
hw/rtl/qee_pkg.sv
hw/rtl/qee_if.sv
hw/rtl/qee_div.sv
hw/rtl/quadrature_edge_emitter.sv
tb/quadrature_edge_emitter_test.sv
